/* rtl/dfle_pkg.sv */
// Package for the debounced fault latch encoder.
// Holds request and result types, fault bit positions, register indexes
// and the customer code table. No dependencies.
package dfle_pkg;

  localparam int unsigned SampleW    = 12;
  localparam int unsigned WordW      = 20;
  localparam int unsigned CodeW      = 5;
  localparam int unsigned PrescaleW  = 4;
  localparam int unsigned VoltCntW   = 3;
  localparam int unsigned CurrCntW   = 5;
  localparam int unsigned CfgIdxW    = 2;

  localparam int unsigned BitOverVolt    = 6;
  localparam int unsigned BitUnderVolt   = 7;
  localparam int unsigned BitOverCurrent = 9;
  localparam int unsigned BitPeak        = 10;

  localparam logic [SampleW-1:0] SampleMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOverVoltLimit   = 2'd0,
    CfgUnderVoltLimit  = 2'd1,
    CfgOverCurrLimit   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] battery_sample;
    logic [SampleW-1:0] current_sample;
    logic               peak_trip;
    logic               clear_request;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] fault_word;
    logic [CodeW-1:0] fault_code;
    logic [CodeW-1:0] customer_code;
    logic             power_off;
  } rsp_t;

  typedef struct packed {
    logic [SampleW-1:0] over_voltage_limit;
    logic [SampleW-1:0] under_voltage_limit;
    logic [SampleW-1:0] over_current_limit;
  } limits_t;

  typedef struct packed {
    logic advance;
    logic clear;
    logic evaluate;
  } dbnc_ctrl_t;

  function automatic logic [CodeW-1:0] customer_map(input logic [CodeW-1:0] code);
    logic [CodeW-1:0] res;
    unique case (code)
      5'd0:    res = 5'd0;
      5'd1:    res = 5'd25;
      5'd2:    res = 5'd7;
      5'd3:    res = 5'd9;
      5'd4:    res = 5'd22;
      5'd5:    res = 5'd10;
      5'd6:    res = 5'd11;
      5'd7:    res = 5'd1;
      5'd8:    res = 5'd2;
      5'd9:    res = 5'd17;
      5'd10:   res = 5'd12;
      5'd11:   res = 5'd3;
      5'd12:   res = 5'd6;
      5'd13:   res = 5'd4;
      5'd14:   res = 5'd14;
      5'd15:   res = 5'd15;
      5'd16:   res = 5'd16;
      5'd17:   res = 5'd21;
      5'd18:   res = 5'd18;
      5'd19:   res = 5'd19;
      5'd20:   res = 5'd20;
      default: res = 5'd0;
    endcase
    return res;
  endfunction

  function automatic logic [CodeW-1:0] encode_lowest(input logic [WordW-1:0] word);
    logic [CodeW-1:0] res;
    res = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (word[i]) res = CodeW'(i + 1);
    end
    return res;
  endfunction

endpackage

/* rtl/dfle_debounce.sv */
// Debounce counter for one fault condition.
// Depends on dfle_pkg for the control struct.
module dfle_debounce #(
  parameter int unsigned CntW  = 3,
  parameter int unsigned Limit = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfle_pkg::dbnc_ctrl_t ctrl_i,
  input  logic               active_i,
  output logic               hit_o
);
  import dfle_pkg::*;

  localparam logic [CntW-1:0] LimitC = CntW'(Limit);

  logic [CntW-1:0] count_q, count_d, base, inc;

  always_comb begin
    base    = ctrl_i.clear ? '0 : count_q;
    inc     = base + 1'b1;
    hit_o   = 1'b0;
    count_d = count_q;
    if (ctrl_i.advance) begin
      count_d = base;
      if (ctrl_i.evaluate) begin
        if (!active_i) begin
          count_d = '0;
        end else if (inc >= LimitC) begin
          count_d = '0;
          hit_o   = 1'b1;
        end else begin
          count_d = inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* rtl/dfle_core.sv */
// Evaluation core: tick prescaler, three debounce counters, fault latch,
// priority encoder and customer mapping. Depends on dfle_pkg, dfle_debounce.
module dfle_core #(
  parameter int unsigned TICKS_PER_CHECK  = 10,
  parameter int unsigned VOLT_DEBOUNCE    = 5,
  parameter int unsigned CURRENT_DEBOUNCE = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  dfle_pkg::req_t    req_i,
  input  dfle_pkg::limits_t limits_i,
  output dfle_pkg::rsp_t    rsp_o
);
  import dfle_pkg::*;

  localparam logic [PrescaleW-1:0] TicksC = PrescaleW'(TICKS_PER_CHECK);

  logic [PrescaleW-1:0] pre_q, pre_d, pre_inc;
  logic [WordW-1:0]     word_q, word_d, word_base;
  logic [CodeW-1:0]     code_q, code_d;
  logic                 evaluate;
  logic                 hit_ov, hit_uv, hit_oc;
  dbnc_ctrl_t           ctrl;

  assign pre_inc  = pre_q + 1'b1;
  assign evaluate = pre_inc >= TicksC;

  assign ctrl.advance  = advance_i;
  assign ctrl.clear    = req_i.clear_request;
  assign ctrl.evaluate = evaluate;

  dfle_debounce #(.CntW(VoltCntW), .Limit(VOLT_DEBOUNCE)) u_ov (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .active_i(req_i.battery_sample >= limits_i.over_voltage_limit),
    .hit_o(hit_ov)
  );

  dfle_debounce #(.CntW(VoltCntW), .Limit(VOLT_DEBOUNCE)) u_uv (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .active_i(req_i.battery_sample <= limits_i.under_voltage_limit),
    .hit_o(hit_uv)
  );

  dfle_debounce #(.CntW(CurrCntW), .Limit(CURRENT_DEBOUNCE)) u_oc (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .active_i(req_i.current_sample >= limits_i.over_current_limit),
    .hit_o(hit_oc)
  );

  always_comb begin
    pre_d     = evaluate ? '0 : pre_inc;
    word_base = req_i.clear_request ? '0 : word_q;
    word_d    = word_base;
    code_d    = req_i.clear_request ? '0 : code_q;
    if (evaluate) begin
      word_d[BitOverVolt]    = word_base[BitOverVolt] | hit_ov;
      word_d[BitUnderVolt]   = word_base[BitUnderVolt] | hit_uv;
      word_d[BitOverCurrent] = word_base[BitOverCurrent] | hit_oc;
      word_d[BitPeak]        = word_base[BitPeak] | req_i.peak_trip;
      code_d                 = encode_lowest(word_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      word_q <= '0;
      code_q <= '0;
    end else if (advance_i) begin
      pre_q  <= pre_d;
      word_q <= word_d;
      code_q <= code_d;
    end
  end

  assign rsp_o.fault_word    = word_d;
  assign rsp_o.fault_code    = code_d;
  assign rsp_o.customer_code = customer_map(code_d);
  assign rsp_o.power_off     = |word_d;

endmodule

/* rtl/debounced_fault_latch_encoder_unit.sv */
// Top level of the debounced fault latch encoder: limit registers, input
// register, evaluation core and result register. Depends on dfle_pkg, dfle_core.
//
//  channel  valid        stall        payload
//  in       in_valid_i   in_stall_o   battery_sample_i current_sample_i peak_trip_i
//                                     clear_request_i
//  out      out_valid_o  out_stall_i  fault_word_o fault_code_o customer_code_o power_off_o
//  cfg      cfg_we_i     -            cfg_idx_i cfg_data_i
//
// One request per cycle while the result is not stalled; an accepted request passes
// the input register and the core's combinational update into the result register.
// Reset clears the fault word, code, counters and prescaler and sets the limits to defaults.
// A stalled result holds the result register; the input register then fills
// and in_stall_o rises until the result is taken.
module debounced_fault_latch_encoder_unit #(
  parameter int unsigned TICKS_PER_CHECK  = 10,
  parameter int unsigned VOLT_DEBOUNCE    = 5,
  parameter int unsigned CURRENT_DEBOUNCE = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfle_pkg::SampleW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dfle_pkg::SampleW-1:0]  battery_sample_i,
  input  logic [dfle_pkg::SampleW-1:0]  current_sample_i,
  input  logic                          peak_trip_i,
  input  logic                          clear_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfle_pkg::WordW-1:0]    fault_word_o,
  output logic [dfle_pkg::CodeW-1:0]    fault_code_o,
  output logic [dfle_pkg::CodeW-1:0]    customer_code_o,
  output logic                          power_off_o
);
  import dfle_pkg::*;

  limits_t lim_q;
  req_t    req_q;
  rsp_t    rsp, rsp_q;
  logic    req_vld_q, rsp_vld_q;
  logic    advance;

  assign advance    = req_vld_q & (~rsp_vld_q | ~out_stall_i);
  assign in_stall_o = req_vld_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.over_voltage_limit  <= SampleMax;
      lim_q.under_voltage_limit <= '0;
      lim_q.over_current_limit  <= SampleMax;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOverVoltLimit:  lim_q.over_voltage_limit  <= cfg_data_i;
        CfgUnderVoltLimit: lim_q.under_voltage_limit <= cfg_data_i;
        CfgOverCurrLimit:  lim_q.over_current_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) req_vld_q <= in_valid_i;
      if (advance) begin
        rsp_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q.battery_sample <= battery_sample_i;
      req_q.current_sample <= current_sample_i;
      req_q.peak_trip      <= peak_trip_i;
      req_q.clear_request  <= clear_request_i;
    end
    if (advance) rsp_q <= rsp;
  end

  dfle_core #(
    .TICKS_PER_CHECK (TICKS_PER_CHECK),
    .VOLT_DEBOUNCE   (VOLT_DEBOUNCE),
    .CURRENT_DEBOUNCE(CURRENT_DEBOUNCE)
  ) u_core (
    .clk_i,
    .rst_ni,
    .advance_i(advance),
    .req_i    (req_q),
    .limits_i (lim_q),
    .rsp_o    (rsp)
  );

  assign out_valid_o     = rsp_vld_q;
  assign fault_word_o    = rsp_q.fault_word;
  assign fault_code_o    = rsp_q.fault_code;
  assign customer_code_o = rsp_q.customer_code;
  assign power_off_o     = rsp_q.power_off;

endmodule
